// ===== hw/rtl/ising_metropolis_spin_flip_defines.svh =====
// assertion macros shared by the spin flip checker
`ifndef ISING_METROPOLIS_SPIN_FLIP_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_FLIP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ISM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ISM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ism_pkg.sv =====
// shared types and constants of the ising spin flip block
package ism_pkg;

	localparam int GRID_SIZE_DEF = 64;

	localparam int COORD_W = 6;
	localparam int FRAC_W = 16;
	localparam int THR_W = 16;
	localparam int MAG_W = 14;
	localparam int BOND_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [THR_W-1:0] THR_TWO_RESET = 16'd24109;
	localparam logic [THR_W-1:0] THR_FOUR_RESET = 16'd8869;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THR_TWO = 1'b0,
		CFG_THR_FOUR = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_FLIP = 1'b0,
		CMD_CLEAR = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		RD_PREV_IN,
		RD_NEXT,
		RD_SITE
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD_NEXT,
		ST_RD_SITE,
		ST_COMMIT,
		ST_CLR_REPLY
	} state_t;

	typedef struct packed {
		logic cap_in;
		logic rd_en;
		rd_sel_t rd_sel;
		logic cap_prev;
		logic cap_next;
		logic commit;
		logic sweep_start;
		logic sweep_wr;
		logic clr_reply;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/ism_ctrl.sv =====
// sequencer for row reads, commit, result word and grid clear sweep
module ism_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  ism_pkg::dp_status_t    status,
	output ism_pkg::ctrl_cmd_t     cmd
);

	ism_pkg::state_t state_q, state_d;
	logic reply_q, reply_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ism_pkg::ST_SWEEP;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reply_q <= reply_d;
		end
	end

	always_comb begin
		state_d = state_q;
		reply_d = reply_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ism_pkg::ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (status.sweep_last) begin
					state_d = reply_q ? ism_pkg::ST_CLR_REPLY : ism_pkg::ST_IDLE;
				end
			end
			ism_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == ism_pkg::CMD_CLEAR) begin
						cmd.sweep_start = 1'b1;
						reply_d = 1'b1;
						state_d = ism_pkg::ST_SWEEP;
					end else begin
						// row above the site is read straight from the input word
						cmd.cap_in = 1'b1;
						cmd.rd_en = 1'b1;
						cmd.rd_sel = ism_pkg::RD_PREV_IN;
						state_d = ism_pkg::ST_RD_NEXT;
					end
				end
			end
			ism_pkg::ST_RD_NEXT: begin
				cmd.cap_prev = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = ism_pkg::RD_NEXT;
				state_d = ism_pkg::ST_RD_SITE;
			end
			ism_pkg::ST_RD_SITE: begin
				cmd.cap_next = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = ism_pkg::RD_SITE;
				state_d = ism_pkg::ST_COMMIT;
			end
			ism_pkg::ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = ism_pkg::ST_IDLE;
				end
			end
			ism_pkg::ST_CLR_REPLY: begin
				if (status.out_free) begin
					cmd.clr_reply = 1'b1;
					reply_d = 1'b0;
					state_d = ism_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ism_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ism_datapath.sv =====
// spin row memory, neighbor capture, acceptance test, running sums, result register
module ism_datapath #(
	parameter int GRID_SIZE = ism_pkg::GRID_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ism_pkg::ctrl_cmd_t                    cmd,
	output ism_pkg::dp_status_t                   status,
	input  logic [ism_pkg::COORD_W-1:0]           row,
	input  logic [ism_pkg::COORD_W-1:0]           column,
	input  logic [ism_pkg::FRAC_W-1:0]            random_fraction,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ism_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ism_pkg::THR_W-1:0]             cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  flipped,
	output logic                                  site_spin,
	output logic signed [ism_pkg::MAG_W-1:0]      magnetisation_sum,
	output logic signed [ism_pkg::BOND_W-1:0]     bond_sum
);

	localparam int IDX_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int COORD_SPAN = 2 ** ism_pkg::COORD_W;
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int MAG_W = ism_pkg::MAG_W;
	localparam int BOND_W = ism_pkg::BOND_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(GRID_SIZE - 1);
	localparam logic [MAG_W-1:0] MAG_INIT = MAG_W'(-CELLS);
	localparam logic [BOND_W-1:0] BOND_INIT = BOND_W'(4 * CELLS);

	// coordinate wrap, built at elaboration
	logic [IDX_W-1:0] wrap_tab [COORD_SPAN];
	for (genvar v = 0; v < COORD_SPAN; v++) begin : g_wrap
		localparam int WV = v % GRID_SIZE;
		assign wrap_tab[v] = IDX_W'(WV);
	end

	logic [IDX_W-1:0] in_r, in_c, in_rp;
	logic [IDX_W-1:0] r_q, c_q, rn, cn, cp;
	logic [ism_pkg::FRAC_W-1:0] frac_q;
	logic [ism_pkg::THR_W-1:0] thr_two_q, thr_four_q;

	logic [GRID_SIZE-1:0] spin_mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [GRID_SIZE-1:0] wr_data, row_new;
	logic wr_en;

	logic [IDX_W-1:0] sweep_cnt_q;
	logic prev_bit_q, next_bit_q;

	logic site_bit, left_bit, right_bit, accept;
	logic [2:0] ones, agree;
	logic [MAG_W-1:0] mag_q, mag_delta, mag_nxt, mag_out_q;
	logic [BOND_W-1:0] bond_q, bond_delta, bond_nxt, bond_out_q;
	logic out_valid_q, flipped_q, site_q;

	assign in_r = wrap_tab[row];
	assign in_c = wrap_tab[column];
	assign in_rp = (in_r == '0) ? LAST : in_r - IDX_W'(1);

	assign rn = (r_q == LAST) ? '0 : r_q + IDX_W'(1);
	assign cn = (c_q == LAST) ? '0 : c_q + IDX_W'(1);
	assign cp = (c_q == '0) ? LAST : c_q - IDX_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			r_q <= in_r;
			c_q <= in_c;
			frac_q <= random_fraction;
		end
		if (cmd.cap_prev) begin
			prev_bit_q <= rd_data_q[c_q];
		end
		if (cmd.cap_next) begin
			next_bit_q <= rd_data_q[c_q];
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			ism_pkg::RD_PREV_IN: rd_addr = in_rp;
			ism_pkg::RD_NEXT:    rd_addr = rn;
			ism_pkg::RD_SITE:    rd_addr = r_q;
			default:             rd_addr = r_q;
		endcase
	end

	// one row word per grid row
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= spin_mem[rd_addr];
		end
		if (wr_en) begin
			spin_mem[wr_addr] <= wr_data;
		end
	end

	assign wr_en = cmd.sweep_wr | cmd.commit;
	assign wr_addr = cmd.sweep_wr ? sweep_cnt_q : r_q;
	assign wr_data = cmd.sweep_wr ? '0 : row_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_start) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_cnt_q <= (sweep_cnt_q == LAST) ? '0 : sweep_cnt_q + IDX_W'(1);
		end
	end

	assign status.sweep_last = (sweep_cnt_q == LAST);
	assign status.out_free = !out_valid_q || out_ready;

	// rd_data_q holds the site row during commit
	assign site_bit = rd_data_q[c_q];
	assign left_bit = rd_data_q[cp];
	assign right_bit = rd_data_q[cn];
	assign ones = 3'(prev_bit_q) + 3'(next_bit_q) + 3'(left_bit) + 3'(right_bit);
	// neighbors that match the site spin; product is 2*agree - 4
	assign agree = site_bit ? ones : 3'd4 - ones;

	always_comb begin
		case (agree)
			3'd3: accept = (frac_q < thr_two_q);
			3'd4: accept = (frac_q < thr_four_q);
			default: accept = 1'b1;
		endcase
		case (agree)
			3'd0: bond_delta = BOND_W'(16);
			3'd1: bond_delta = BOND_W'(8);
			3'd3: bond_delta = BOND_W'(-8);
			3'd4: bond_delta = BOND_W'(-16);
			default: bond_delta = '0;
		endcase
		row_new = rd_data_q;
		row_new[c_q] = site_bit ^ accept;
	end

	assign mag_delta = site_bit ? MAG_W'(-2) : MAG_W'(2);
	assign mag_nxt = accept ? mag_q + mag_delta : mag_q;
	assign bond_nxt = accept ? bond_q + bond_delta : bond_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= MAG_INIT;
			bond_q <= BOND_INIT;
		end else if (cmd.sweep_start) begin
			mag_q <= MAG_INIT;
			bond_q <= BOND_INIT;
		end else if (cmd.commit) begin
			mag_q <= mag_nxt;
			bond_q <= bond_nxt;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_two_q <= ism_pkg::THR_TWO_RESET;
			thr_four_q <= ism_pkg::THR_FOUR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ism_pkg::CFG_THR_TWO:  thr_two_q <= cfg_data;
				ism_pkg::CFG_THR_FOUR: thr_four_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.clr_reply) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			flipped_q <= accept;
			site_q <= site_bit ^ accept;
			mag_out_q <= mag_nxt;
			bond_out_q <= bond_nxt;
		end else if (cmd.clr_reply) begin
			flipped_q <= 1'b0;
			site_q <= 1'b0;
			mag_out_q <= mag_q;
			bond_out_q <= bond_q;
		end
	end

	assign out_valid = out_valid_q;
	assign flipped = flipped_q;
	assign site_spin = site_q;
	assign magnetisation_sum = $signed(mag_out_q);
	assign bond_sum = $signed(bond_out_q);

endmodule

// ===== hw/rtl/ising_metropolis_spin_flip.sv =====
// top level of the 2d ising metropolis spin flip block
//
//   channel  signals                                      direction
//   in       in_valid/in_ready, command, row, column,     into block
//            random_fraction
//   out      out_valid/out_ready, flipped, site_spin,     out of block
//            magnetisation_sum, bond_sum
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     into block, always ready
//
// a flip word does three single-port reads of the row memory (row above,
// row below, site row) and one write-back, the result word registered with the write-back
// a clear word sweeps the row memory one row a cycle, then gives its result word
// after reset the same sweep runs over every row with in_ready low
// a result left waiting holds the next word at its commit step until out_ready
module ising_metropolis_spin_flip #(
	parameter int GRID_SIZE = ism_pkg::GRID_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [ism_pkg::COORD_W-1:0]           row,
	input  logic [ism_pkg::COORD_W-1:0]           column,
	input  logic [ism_pkg::FRAC_W-1:0]            random_fraction,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  flipped,
	output logic                                  site_spin,
	output logic signed [ism_pkg::MAG_W-1:0]      magnetisation_sum,
	output logic signed [ism_pkg::BOND_W-1:0]     bond_sum,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ism_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ism_pkg::THR_W-1:0]             cfg_data
);

	ism_pkg::ctrl_cmd_t cmd;
	ism_pkg::dp_status_t status;

	ism_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.status   (status),
		.cmd      (cmd)
	);

	ism_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.row               (row),
		.column            (column),
		.random_fraction   (random_fraction),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.flipped           (flipped),
		.site_spin         (site_spin),
		.magnetisation_sum (magnetisation_sum),
		.bond_sum          (bond_sum)
	);

endmodule

// ===== hw/rtl/ism_checker.sv =====
// port-level checks of the spin flip block, bound to the top level
`include "ising_metropolis_spin_flip_defines.svh"

module ism_checker #(
	parameter int GRID_SIZE = ism_pkg::GRID_SIZE_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              flipped,
	input logic                              site_spin,
	input logic signed [ism_pkg::MAG_W-1:0]  magnetisation_sum,
	input logic signed [ism_pkg::BOND_W-1:0] bond_sum
);

	// sums keep the parity of the cell count; bonds move in steps of eight
	localparam logic ODD_GRID = 1'(GRID_SIZE % 2);

	`ISM_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready, "accepted a word while busy")
	`ISM_ASSERT_SAME(a_mag_parity, out_valid, magnetisation_sum[0] == ODD_GRID, "magnetisation parity off")
	`ISM_ASSERT_SAME(a_bond_step, out_valid, bond_sum[2:0] == {ODD_GRID, 2'b00}, "bond sum off its step")
	`ISM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(flipped) && $stable(site_spin) && $stable(magnetisation_sum) && $stable(bond_sum), "stalled result word changed")

endmodule

bind ising_metropolis_spin_flip ism_checker #(.GRID_SIZE(GRID_SIZE)) u_ism_checker (.*);
